>>> rtl/plqm_pkg.sv
// Shared types, constants and codes of the pooled linked queue manager
package plqm_pkg;

  // default pool and queue counts
  localparam int POOL_SIZE_DEF   = 32;
  localparam int QUEUE_COUNT_DEF = 8;

  // fixed field widths of the item ports
  localparam int REQ_W   = 3;
  localparam int QID_W   = 3;
  localparam int ENTRY_W = 5;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 3'd0,
    REQ_FREE    = 3'd1,
    REQ_ENQUEUE = 3'd2,
    REQ_DEQUEUE = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_PEEK    = 3'd5
  } req_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ,
    S_HEAD,
    S_DQ2,
    S_WALK,
    S_UNLINK,
    S_HOLD
  } state_t;

  // read and write strobes of one memory
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

>>> rtl/pooled_linked_queue_manager.sv
// Alloc, free and rejected requests finish in S_EXEC; enqueue finishes in S_EXEC or S_ENQ,
// peek in S_HEAD, dequeue in S_HEAD or S_DQ2, and remove in S_WALK or S_UNLINK after a walk
// of at most one lap of the pool. One item is in flight at a time; the next is taken the cycle
// after the result is registered; a result that waits on a stall holds the sequencer in S_HOLD.
// Reset: synchronous; links and tails carry valid bits, so no clearing pass is needed
// and requests are taken as soon as reset is released.
module pooled_linked_queue_manager #(
  parameter int POOL_SIZE   = plqm_pkg::POOL_SIZE_DEF,
  parameter int QUEUE_COUNT = plqm_pkg::QUEUE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [plqm_pkg::REQ_W-1:0]   req_type,
  input  logic [plqm_pkg::QID_W-1:0]   queue_id,
  input  logic [plqm_pkg::ENTRY_W-1:0] entry_index,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [plqm_pkg::ENTRY_W-1:0] result_entry,
  output logic                         success,
  output logic                         queue_empty
);
  import plqm_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);
  localparam int PW = $clog2(POOL_SIZE + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  mem_ctl_t      link_ctl, tail_ctl;
  logic [AW-1:0] link_rd_addr, link_wr_addr;
  logic [PW-1:0] link_wr_data, link_rd_data;
  logic [QW-1:0] tail_rd_addr, tail_wr_addr;
  logic [PW-1:0] tail_wr_data, tail_rd_data;

  // sequencer
  plqm_ctrl #(
    .POOL_SIZE   (POOL_SIZE),
    .QUEUE_COUNT (QUEUE_COUNT),
    .AW          (AW),
    .PW          (PW),
    .QW          (QW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .queue_id     (queue_id),
    .entry_index  (entry_index),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_entry (result_entry),
    .success      (success),
    .queue_empty  (queue_empty),
    .link_ctl     (link_ctl),
    .link_rd_addr (link_rd_addr),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .link_rd_data (link_rd_data),
    .tail_ctl     (tail_ctl),
    .tail_rd_addr (tail_rd_addr),
    .tail_wr_addr (tail_wr_addr),
    .tail_wr_data (tail_wr_data),
    .tail_rd_data (tail_rd_data)
  );

  // next pointers of the pool
  plqm_link_mem #(
    .POOL_SIZE (POOL_SIZE),
    .AW        (AW),
    .PW        (PW)
  ) u_link_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (link_ctl),
    .rd_addr (link_rd_addr),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_data (link_rd_data)
  );

  // queue tails
  plqm_tail_mem #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .POOL_SIZE   (POOL_SIZE),
    .QW          (QW),
    .PW          (PW)
  ) u_tail_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tail_ctl),
    .rd_addr (tail_rd_addr),
    .wr_addr (tail_wr_addr),
    .wr_data (tail_wr_data),
    .rd_data (tail_rd_data)
  );

endmodule

>>> rtl/plqm_link_mem.sv
// Next-pointer memory with per-entry valid bits standing in for the chained reset
module plqm_link_mem #(
  parameter int POOL_SIZE = 32,
  parameter int AW        = 5,
  parameter int PW        = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  plqm_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  input  logic [PW-1:0]      wr_data,
  output logic [PW-1:0]      rd_data
);
  import plqm_pkg::*;

  logic [PW-1:0]        mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] vld;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered read, read-first; unwritten entries link to their successor
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : PW'(rd_addr) + PW'(1);
    end
  end

endmodule

>>> rtl/plqm_tail_mem.sv
// Queue tail memory with per-queue valid bits, unwritten tails read as null
module plqm_tail_mem #(
  parameter int QUEUE_COUNT = 8,
  parameter int POOL_SIZE   = 32,
  parameter int QW          = 3,
  parameter int PW          = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  plqm_pkg::mem_ctl_t ctl,
  input  logic [QW-1:0]      rd_addr,
  input  logic [QW-1:0]      wr_addr,
  input  logic [PW-1:0]      wr_data,
  output logic [PW-1:0]      rd_data
);
  import plqm_pkg::*;

  localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);

  logic [PW-1:0]          mem [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] vld;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered read, read-first
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : NIL;
    end
  end

endmodule

>>> rtl/plqm_ctrl.sv
// Request sequencer: pointer read-modify-write over the link and tail memories
module plqm_ctrl #(
  parameter int POOL_SIZE   = 32,
  parameter int QUEUE_COUNT = 8,
  parameter int AW          = 5,
  parameter int PW          = 6,
  parameter int QW          = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [plqm_pkg::REQ_W-1:0]   req_type,
  input  logic [plqm_pkg::QID_W-1:0]   queue_id,
  input  logic [plqm_pkg::ENTRY_W-1:0] entry_index,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [plqm_pkg::ENTRY_W-1:0] result_entry,
  output logic                         success,
  output logic                         queue_empty,
  output plqm_pkg::mem_ctl_t           link_ctl,
  output logic [AW-1:0]                link_rd_addr,
  output logic [AW-1:0]                link_wr_addr,
  output logic [PW-1:0]                link_wr_data,
  input  logic [PW-1:0]                link_rd_data,
  output plqm_pkg::mem_ctl_t           tail_ctl,
  output logic [QW-1:0]                tail_rd_addr,
  output logic [QW-1:0]                tail_wr_addr,
  output logic [PW-1:0]                tail_wr_data,
  input  logic [PW-1:0]                tail_rd_data
);
  import plqm_pkg::*;

  localparam logic [PW-1:0] NIL       = PW'(POOL_SIZE);
  localparam logic [AW-1:0] LAST_STEP = AW'(POOL_SIZE - 1);

  state_t state, state_next;

  // latched request
  req_e               op;
  logic [QID_W-1:0]   qid;
  logic [ENTRY_W-1:0] ent;

  // pointer registers
  logic [PW-1:0] free_head, free_head_next;
  logic [PW-1:0] tail;
  logic [PW-1:0] prev, prev_next;
  logic [PW-1:0] cur, cur_next;
  logic [AW-1:0] steps, steps_next;

  // held result when the output register is still occupied
  logic [ENTRY_W-1:0] pend_res;
  logic               pend_ok, pend_empty;

  // finishing values
  logic               done;
  logic [ENTRY_W-1:0] fin_res;
  logic               fin_ok, fin_empty;

  logic          accept, slot_free, load_fin, load_pend;
  logic          q_ok, p_ok, t_nil;
  logic [PW-1:0] p_ptr, t_now, ring;

  // shared conditions
  assign accept    = req_valid && !req_stall;
  assign slot_free = !res_valid || !res_stall;
  assign q_ok      = 32'(qid) < QUEUE_COUNT;
  assign p_ok      = 32'(ent) < POOL_SIZE;
  assign p_ptr     = PW'(ent);
  assign t_now     = (state == S_EXEC) ? tail_rd_data : tail;
  assign t_nil     = (t_now == NIL);
  assign ring      = (link_rd_data == NIL) ? t_now : link_rd_data;
  assign req_stall = (state != S_IDLE);
  assign load_fin  = done && slot_free;
  assign load_pend = (state == S_HOLD) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    if (done) begin
      state_next = slot_free ? S_IDLE : S_HOLD;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state_next = S_EXEC;
        end
        S_EXEC: begin
          case (op)
            REQ_ENQUEUE:             state_next = S_ENQ;
            REQ_DEQUEUE, REQ_PEEK:   state_next = S_HEAD;
            REQ_REMOVE:              state_next = S_WALK;
            default:                 state_next = S_IDLE;
          endcase
        end
        S_HEAD:  state_next = S_DQ2;
        S_WALK: begin
          state_next = (ring == p_ptr) ? S_UNLINK : S_WALK;
        end
        S_HOLD: begin
          if (slot_free) state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  // memory commands, result and pointer updates
  always_comb begin
    link_ctl       = '0;
    link_rd_addr   = '0;
    link_wr_addr   = '0;
    link_wr_data   = '0;
    tail_ctl       = '0;
    tail_rd_addr   = QW'(queue_id);
    tail_wr_addr   = QW'(qid);
    tail_wr_data   = '0;
    done           = 1'b0;
    fin_res        = '0;
    fin_ok         = 1'b0;
    fin_empty      = 1'b0;
    free_head_next = free_head;
    prev_next      = prev;
    cur_next       = cur;
    steps_next     = steps;
    case (state)
      S_IDLE: begin
        // fetch the tail and the free-list successor up front
        tail_ctl.rd  = accept;
        link_ctl.rd  = accept;
        link_rd_addr = AW'(free_head);
      end
      S_EXEC: begin
        case (op)
          REQ_ALLOC: begin
            done = 1'b1;
            if (free_head != NIL) begin
              free_head_next = link_rd_data;
              link_ctl.wr    = 1'b1;
              link_wr_addr   = AW'(free_head);
              link_wr_data   = NIL;
              fin_res        = ENTRY_W'(free_head);
              fin_ok         = 1'b1;
            end
          end
          REQ_FREE: begin
            done = 1'b1;
            if (p_ok) begin
              link_ctl.wr    = 1'b1;
              link_wr_addr   = AW'(p_ptr);
              link_wr_data   = free_head;
              free_head_next = p_ptr;
              fin_ok         = 1'b1;
            end
          end
          REQ_ENQUEUE: begin
            if (!q_ok) begin
              done      = 1'b1;
              fin_empty = 1'b1;
            end else if (!p_ok) begin
              done      = 1'b1;
              fin_empty = t_nil;
            end else if (t_nil) begin
              // first entry closes the ring on itself
              done         = 1'b1;
              link_ctl.wr  = 1'b1;
              link_wr_addr = AW'(p_ptr);
              link_wr_data = p_ptr;
              tail_ctl.wr  = 1'b1;
              tail_wr_data = p_ptr;
              fin_ok       = 1'b1;
            end else begin
              // read old head link and point the tail at the new entry
              link_ctl.rd  = 1'b1;
              link_rd_addr = AW'(t_now);
              link_ctl.wr  = 1'b1;
              link_wr_addr = AW'(t_now);
              link_wr_data = p_ptr;
            end
          end
          REQ_DEQUEUE, REQ_PEEK: begin
            if (!q_ok || t_nil) begin
              done      = 1'b1;
              fin_empty = 1'b1;
            end else begin
              link_ctl.rd  = 1'b1;
              link_rd_addr = AW'(t_now);
            end
          end
          REQ_REMOVE: begin
            if (!q_ok || t_nil) begin
              done      = 1'b1;
              fin_empty = 1'b1;
            end else if (!p_ok) begin
              done = 1'b1;
            end else begin
              link_ctl.rd  = 1'b1;
              link_rd_addr = AW'(t_now);
              prev_next    = t_now;
              steps_next   = '0;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_ENQ: begin
        // new entry takes over the old head, unless it is the tail itself
        done = 1'b1;
        if (p_ptr != tail) begin
          link_ctl.wr  = 1'b1;
          link_wr_addr = AW'(p_ptr);
          link_wr_data = ring;
        end
        tail_ctl.wr  = 1'b1;
        tail_wr_data = p_ptr;
        fin_ok       = 1'b1;
      end
      S_HEAD: begin
        if (op == REQ_PEEK) begin
          done    = 1'b1;
          fin_res = ENTRY_W'(ring);
          fin_ok  = 1'b1;
        end else if (ring == tail) begin
          // single entry leaves
          done         = 1'b1;
          tail_ctl.wr  = 1'b1;
          tail_wr_data = NIL;
          fin_res      = ENTRY_W'(ring);
          fin_ok       = 1'b1;
          fin_empty    = 1'b1;
        end else begin
          link_ctl.rd  = 1'b1;
          link_rd_addr = AW'(ring);
          cur_next     = ring;
        end
      end
      S_DQ2: begin
        done         = 1'b1;
        link_ctl.wr  = 1'b1;
        link_wr_addr = AW'(tail);
        link_wr_data = ring;
        fin_res      = ENTRY_W'(cur);
        fin_ok       = 1'b1;
      end
      S_WALK: begin
        if (ring == p_ptr) begin
          // found: clear its link and, unless it is the only entry, read its successor in the same cycle
          link_ctl.wr  = 1'b1;
          link_wr_addr = AW'(p_ptr);
          link_wr_data = NIL;
          if (ring == prev) begin
            done         = 1'b1;
            tail_ctl.wr  = 1'b1;
            tail_wr_data = NIL;
            fin_res      = ent;
            fin_ok       = 1'b1;
            fin_empty    = 1'b1;
          end else begin
            link_ctl.rd  = 1'b1;
            link_rd_addr = AW'(ring);
            cur_next     = ring;
          end
        end else if (ring == tail || steps == LAST_STEP) begin
          done = 1'b1;
        end else begin
          link_ctl.rd  = 1'b1;
          link_rd_addr = AW'(ring);
          prev_next    = ring;
          steps_next   = steps + AW'(1);
        end
      end
      S_UNLINK: begin
        done         = 1'b1;
        link_ctl.wr  = 1'b1;
        link_wr_addr = AW'(prev);
        link_wr_data = ring;
        if (cur == tail) begin
          tail_ctl.wr  = 1'b1;
          tail_wr_data = prev;
        end
        fin_res = ent;
        fin_ok  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      if (load_fin || load_pend) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req_e'(req_type);
      qid <= queue_id;
      ent <= entry_index;
    end
    if (state == S_EXEC) begin
      tail <= tail_rd_data;
    end
    prev  <= prev_next;
    cur   <= cur_next;
    steps <= steps_next;
    if (load_fin) begin
      result_entry <= fin_res;
      success      <= fin_ok;
      queue_empty  <= fin_empty;
    end else if (load_pend) begin
      result_entry <= pend_res;
      success      <= pend_ok;
      queue_empty  <= pend_empty;
    end
    if (done && !slot_free) begin
      pend_res   <= fin_res;
      pend_ok    <= fin_ok;
      pend_empty <= fin_empty;
    end
  end

endmodule

>>> rtl/plqm_checker.sv
// Port-level checks of the queue manager and their binding to the top level
module plqm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic [plqm_pkg::ENTRY_W-1:0] result_entry,
  input logic                         success,
  input logic                         queue_empty
);
  import plqm_pkg::*;

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while an item was in flight");

  // a new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without an accepted item");

  // failed requests carry no entry
  a_fail_no_entry: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !success) |-> (result_entry == '0))
    else $error("failed result carries an entry");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(result_entry) &&
                                  $stable(success) && $stable(queue_empty)))
    else $error("stalled result changed");

endmodule

bind pooled_linked_queue_manager plqm_checker u_plqm_checker (.*);

>>> tb/plqm_link_checker.sv
// Link memory mirror and result checker for the pooled linked queue manager
module plqm_link_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  logic [plqm_pkg::REQ_W-1:0]   req_type,
  input  logic [plqm_pkg::QID_W-1:0]   queue_id,
  input  logic [plqm_pkg::ENTRY_W-1:0] entry_index,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  logic [plqm_pkg::ENTRY_W-1:0] result_entry,
  input  logic                         success,
  input  logic                         queue_empty,
  output int                           mismatches,
  output int                           outstanding
);
  import plqm_pkg::*;

  localparam int         POOL = POOL_SIZE_DEF;
  localparam int         QCNT = QUEUE_COUNT_DEF;
  localparam logic [5:0] NIL  = 6'(POOL);

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               ok;
    logic               empty;
  } reply_t;

  // mirrored pointer state: next links, free-list head, queue tails
  logic [5:0] link_mem [POOL];
  logic [5:0] free_top;
  logic [5:0] tail_of  [QCNT];

  // replies predicted but not yet seen on the result channel
  reply_t replies_due [$];
  int     bad = 0;

  function automatic void clear_mirror();
    for (int i = 0; i < POOL; i++) link_mem[i] = 6'(i + 1);
    free_top = '0;
    for (int i = 0; i < QCNT; i++) tail_of[i] = NIL;
  endfunction

  function automatic logic [5:0] link_at(input logic [5:0] idx);
    return (idx >= POOL) ? NIL : link_mem[idx[4:0]];
  endfunction

  function automatic void set_link(input logic [5:0] idx, input logic [5:0] val);
    if (idx < POOL) link_mem[idx[4:0]] = val;
  endfunction

  // successor within the ring ending at t; a null link closes back to t
  function automatic logic [5:0] ring_step(input logic [5:0] idx, input logic [5:0] t);
    logic [5:0] n;
    n = link_at(idx);
    return (n == NIL) ? t : n;
  endfunction

  // apply one request to the mirror and work out its reply
  function automatic reply_t predict_reply(input logic [2:0] rt, input logic [2:0] qi,
                                           input logic [4:0] ei);
    reply_t     r;
    logic [5:0] p, t, hd, prv, cur;
    int         steps;
    logic       done;
    r = '0;
    p = {1'b0, ei};
    case (rt)
      REQ_ALLOC: begin
        if (free_top != NIL) begin
          p        = free_top;
          free_top = link_at(p);
          set_link(p, NIL);
          r.entry  = p[4:0];
          r.ok     = 1'b1;
        end
      end
      REQ_FREE: begin
        link_mem[ei] = free_top;
        free_top     = p;
        r.ok         = 1'b1;
      end
      REQ_ENQUEUE, REQ_DEQUEUE, REQ_REMOVE, REQ_PEEK: begin
        t = tail_of[qi];
        if (rt == REQ_ENQUEUE) begin
          if (t == NIL) begin
            link_mem[ei] = p;
          end else begin
            link_mem[ei] = ring_step(t, t);
            set_link(t, p);
          end
          tail_of[qi] = p;
          r.ok        = 1'b1;
        end else if (t != NIL) begin
          if (rt == REQ_DEQUEUE) begin
            hd = ring_step(t, t);
            if (hd == t) tail_of[qi] = NIL;
            else set_link(t, ring_step(hd, t));
            r.entry = hd[4:0];
            r.ok    = 1'b1;
          end else if (rt == REQ_PEEK) begin
            hd      = ring_step(t, t);
            r.entry = hd[4:0];
            r.ok    = 1'b1;
          end else begin
            // walk from the head, at most one lap of the pool
            prv  = t;
            done = 1'b0;
            for (steps = 0; steps < POOL && !done; steps++) begin
              cur = ring_step(prv, t);
              if (cur == p) begin
                if (cur == prv) begin
                  tail_of[qi] = NIL;
                end else begin
                  set_link(prv, ring_step(cur, t));
                  if (cur == t) tail_of[qi] = prv;
                end
                link_mem[ei] = NIL;
                r.entry      = ei;
                r.ok         = 1'b1;
                done         = 1'b1;
              end else if (cur == t) begin
                done = 1'b1;
              end else begin
                prv = cur;
              end
            end
          end
        end
        r.empty = (tail_of[qi] == NIL);
      end
      default: ;
    endcase
    return r;
  endfunction

  // compare taken results, predict accepted requests
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      clear_mirror();
      replies_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (replies_due.size() == 0) begin
          bad++;
          $display("%0t: unexpected item, expected none, got entry %0d success %0d empty %0d",
                   $time, result_entry, success, queue_empty);
        end else begin
          want = replies_due.pop_front();
          if (result_entry !== want.entry) begin
            bad++;
            $display("%0t: result_entry expected %0d got %0d", $time, want.entry, result_entry);
          end
          if (success !== want.ok) begin
            bad++;
            $display("%0t: success expected %0d got %0d", $time, want.ok, success);
          end
          if (queue_empty !== want.empty) begin
            bad++;
            $display("%0t: queue_empty expected %0d got %0d", $time, want.empty, queue_empty);
          end
        end
      end
      if (req_valid && !req_stall)
        replies_due.push_back(predict_reply(req_type, queue_id, entry_index));
    end
    outstanding <= replies_due.size();
    mismatches  <= bad;
  end

endmodule

>>> tb/pooled_linked_queue_manager_tb.sv
// Stimulus, handshake pacing and verdict for the pooled linked queue manager
module pooled_linked_queue_manager_tb;
  import plqm_pkg::*;

  localparam int POOL        = POOL_SIZE_DEF;
  localparam int QCNT        = QUEUE_COUNT_DEF;
  localparam int LOC_FREE    = -2;
  localparam int LOC_HELD    = -1;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int SHAPED_ITEMS = 560;
  localparam int WILD_ITEMS  = 90;

  // request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  logic               clk;
  logic               rst         = 1'b1;
  logic               req_valid   = 1'b0;
  logic               req_stall;
  logic [REQ_W-1:0]   req_type    = '0;
  logic [QID_W-1:0]   queue_id    = '0;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic               res_valid;
  logic               res_stall   = 1'b0;
  logic [ENTRY_W-1:0] result_entry;
  logic               success;
  logic               queue_empty;

  int mismatches;
  int outstanding;

  // where each entry sits as far as the sender knows: free, held, or a queue
  int          home  [POOL];
  int unsigned order [POOL];
  int unsigned stamp = 0;
  int          free_stk [$];
  logic        wild  = 1'b0;
  logic [2:0]  fav_q = '0;
  int          tx_quiet = 0;
  int          rx_quiet = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  pooled_linked_queue_manager u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .queue_id     (queue_id),
    .entry_index  (entry_index),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_entry (result_entry),
    .success      (success),
    .queue_empty  (queue_empty)
  );

  plqm_link_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .queue_id     (queue_id),
    .entry_index  (entry_index),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_entry (result_entry),
    .success      (success),
    .queue_empty  (queue_empty),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: stall for a drawn number of cycles after each taken item
  always @(posedge clk) begin : result_taker
    int unsigned n;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (res_valid && !res_stall) begin
      if (rx_quiet != 0) begin
        rx_quiet--;
        n = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_quiet = $urandom_range(10, 30);
        n = 0;
      end else begin
        n = $urandom_range(0, 9);
      end
      stall_left <= n;
      res_stall  <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      res_stall  <= 1'b0;
    end
  end

  // count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // random entry whose location lies in [lo, hi], or -1 when there is none
  function automatic int pick_where(input int lo, input int hi);
    int found [$];
    for (int i = 0; i < POOL; i++)
      if (home[i] >= lo && home[i] <= hi) found.push_back(i);
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  // mostly one favourite queue so that rings grow long
  function automatic logic [2:0] pick_queue();
    if ($urandom_range(0, 39) == 0) fav_q = 3'($urandom_range(0, QCNT - 1));
    if ($urandom_range(0, 3) == 0) return 3'($urandom_range(0, QCNT - 1));
    return fav_q;
  endfunction

  // offer one item after a drawn gap, wait for it to be taken, track its effect
  task automatic send_item(input logic [2:0] rt, input logic [2:0] qi, input logic [4:0] ei);
    int unsigned gap;
    int          h;
    if (tx_quiet != 0) begin
      tx_quiet--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      tx_quiet = $urandom_range(10, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
    end
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= rt;
    queue_id    <= qi;
    entry_index <= ei;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (!wild) begin
      case (rt)
        REQ_ALLOC: if (free_stk.size() != 0) home[free_stk.pop_front()] = LOC_HELD;
        REQ_FREE: begin
          free_stk.push_front(int'(ei));
          home[ei] = LOC_FREE;
        end
        REQ_ENQUEUE: begin
          home[ei]  = int'(qi);
          order[ei] = stamp;
          stamp++;
        end
        REQ_DEQUEUE: begin
          h = -1;
          for (int i = 0; i < POOL; i++)
            if (home[i] == int'(qi) && (h < 0 || order[i] < order[h])) h = i;
          if (h >= 0) home[h] = LOC_HELD;
        end
        REQ_REMOVE: if (home[ei] == int'(qi)) home[ei] = LOC_HELD;
        default: ;
      endcase
    end
  endtask

  // hold the request side until every reply is back
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int               roll, e, counted;
    logic [REQ_W-1:0] rt;
    logic [QID_W-1:0] qi;
    logic [4:0]       ei;
    for (int i = 0; i < POOL; i++) begin
      home[i] = LOC_FREE;
      free_stk.push_back(i);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queues, tail and middle removal, single and multi dequeue
    send_item(REQ_ALLOC,   3'd0, 5'd0);
    send_item(REQ_ALLOC,   3'd7, 5'd31);
    send_item(REQ_ALLOC,   3'd0, 5'd0);
    send_item(REQ_PEEK,    3'd7, 5'd0);
    send_item(REQ_DEQUEUE, 3'd7, 5'd31);
    send_item(REQ_REMOVE,  3'd3, 5'd31);
    send_item(REQ_ENQUEUE, 3'd7, 5'd0);
    send_item(REQ_ENQUEUE, 3'd7, 5'd1);
    send_item(REQ_ENQUEUE, 3'd7, 5'd2);
    send_item(REQ_PEEK,    3'd7, 5'd31);
    send_item(REQ_REMOVE,  3'd7, 5'd31);
    send_item(REQ_REMOVE,  3'd7, 5'd1);
    send_item(REQ_REMOVE,  3'd7, 5'd2);
    send_item(REQ_DEQUEUE, 3'd7, 5'd0);
    send_item(REQ_ENQUEUE, 3'd0, 5'd1);
    send_item(REQ_ENQUEUE, 3'd0, 5'd2);
    send_item(REQ_DEQUEUE, 3'd0, 5'd0);
    send_item(REQ_REMOVE,  3'd0, 5'd2);
    send_item(REQ_FREE,    3'd7, 5'd0);
    send_item(REQ_FREE,    3'd0, 5'd1);
    send_item(REQ_FREE,    3'd7, 5'd2);
    send_item(REQ_UNUSED_LO, 3'd7, 5'd31);
    send_item(REQ_UNUSED_HI, 3'd0, 5'd0);
    settle();

    // random well-formed traffic with some harmless noise
    counted = 0;
    while (counted < SHAPED_ITEMS) begin
      // occasionally run the free list dry and ask once more
      if ($urandom_range(0, 59) == 0) begin
        while (free_stk.size() != 0) begin
          send_item(REQ_ALLOC, pick_queue(), 5'($urandom_range(0, POOL - 1)));
          counted++;
        end
        send_item(REQ_ALLOC, pick_queue(), 5'($urandom_range(0, POOL - 1)));
        counted++;
      end
      if ($urandom_range(0, 149) == 0) settle();
      roll = $urandom_range(0, 99);
      qi   = pick_queue();
      ei   = 5'($urandom_range(0, POOL - 1));
      if (roll < 22) begin
        rt = REQ_ALLOC;
      end else if (roll < 57) begin
        e = pick_where(LOC_HELD, LOC_HELD);
        if (e < 0) begin
          rt = REQ_ALLOC;
        end else begin
          ei = 5'(e);
          rt = (roll < 32) ? REQ_FREE : REQ_ENQUEUE;
        end
      end else if (roll < 70) begin
        rt = REQ_DEQUEUE;
      end else if (roll < 82) begin
        rt = REQ_REMOVE;
        e  = pick_where(0, QCNT - 1);
        if (e >= 0) begin
          ei = 5'(e);
          qi = 3'(home[e]);
        end
      end else if (roll < 87) begin
        // any entry, usually not in this queue
        rt = REQ_REMOVE;
      end else if (roll < 96) begin
        rt = REQ_PEEK;
      end else begin
        rt = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      end
      send_item(rt, qi, ei);
      if (rt <= REQ_PEEK) counted++;
    end

    // misuse at the end: double frees, re-enqueues, broken rings
    wild = 1'b1;
    repeat (WILD_ITEMS)
      send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                5'($urandom_range(0, POOL - 1)));

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
